### rtl/core/dtas_pkg.sv
// Shared constants and helpers for the date and time adder.
// No dependencies; used by datetime_add_seconds.
`timescale 1ns / 1ps
`default_nettype none

package dtas_pkg;

	localparam int unsigned MAX_YEAR_DEF = 9999;

	// Reciprocals for division by constants: q = (x * M) >> S.
	localparam int unsigned DIV100_S = 19;
	localparam logic [12:0] DIV100_M = 13'd5243;

	localparam int unsigned DIV675_S = 35;
	localparam longint unsigned DIV675_L = ((64'd1 << 35) + 64'd674) / 64'd675;
	localparam logic [25:0] DIV675_M = 26'(DIV675_L);

	localparam int unsigned DIV400Y_S = 41;
	localparam longint unsigned DIV400Y_L = ((64'd1 << 41) + 64'd146096) / 64'd146097;
	localparam logic [23:0] DIV400Y_M = 24'(DIV400Y_L);

	localparam int unsigned DIV60A_S = 23;
	localparam longint unsigned DIV60A_L = ((64'd1 << 23) + 64'd59) / 64'd60;
	localparam logic [17:0] DIV60A_M = 18'(DIV60A_L);

	localparam int unsigned DIV60B_S = 17;
	localparam longint unsigned DIV60B_L = ((64'd1 << 17) + 64'd59) / 64'd60;
	localparam logic [11:0] DIV60B_M = 12'(DIV60B_L);

	localparam int unsigned DIV4Y_S = 26;
	localparam longint unsigned DIV4Y_L = ((64'd1 << 26) + 64'd1460) / 64'd1461;
	localparam logic [15:0] DIV4Y_M = 16'(DIV4Y_L);

	localparam logic [16:0] SECS_PER_DAY = 17'd86400;

	// Days before the first of the given month in a common year.
	function automatic logic [8:0] month_start(input logic [3:0] mon);
		logic [8:0] v;
		v = 9'd0;
		case (mon)
			4'd2: v = 9'd31;
			4'd3: v = 9'd59;
			4'd4: v = 9'd90;
			4'd5: v = 9'd120;
			4'd6: v = 9'd151;
			4'd7: v = 9'd181;
			4'd8: v = 9'd212;
			4'd9: v = 9'd243;
			4'd10: v = 9'd273;
			4'd11: v = 9'd304;
			4'd12: v = 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### rtl/core/datetime_add_seconds.sv
// Adds an unsigned count of seconds to a proleptic Gregorian date and time.
// Depends on dtas_pkg for reciprocal constants and the month table.
//
// The block takes one transaction on the input channel (in_valid, in_stall)
// and delivers one result transaction on the output channel (out_valid,
// out_stall). A transaction moves when valid is high and stall is low.
// A new input can be taken in every cycle unless in_stall is high, so the
// sustained rate is one transaction per cycle while the output does not stall.
// The work runs through nine pipeline stages and an output register:
// day count, seconds-of-day and offset split, day carry, then successive
// 400, 100, 4 and 1 year cycle splits and the month search.
// Reset clears every stage valid bit and the output valid; no payload is
// kept. While a result waits under out_stall, the whole pipeline holds and
// in_stall is raised, so nothing is lost or repeated. Results past the
// maximum year are clamped to its last second with year_overflow set.
`timescale 1ns / 1ps
`default_nettype none

module datetime_add_seconds #(
	parameter int unsigned MAX_YEAR = dtas_pkg::MAX_YEAR_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [13:0] start_year,
	input  wire logic [3:0]  start_month,
	input  wire logic [4:0]  start_day,
	input  wire logic [4:0]  start_hour,
	input  wire logic [5:0]  start_minute,
	input  wire logic [5:0]  start_second,
	input  wire logic [31:0] offset_seconds,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [13:0]      end_year,
	output logic [3:0]       end_month,
	output logic [4:0]       end_day,
	output logic [4:0]       end_hour,
	output logic [5:0]       end_minute,
	output logic [5:0]       end_second,
	output logic             year_overflow
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic out_valid_q;

	assign en = !(out_valid_q && out_stall);
	assign in_stall = out_valid_q && out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8;
			out_valid_q <= v_s9;
		end
	end

	// Stage 1: year quotients, offset in whole days.
	logic [13:0] k_c;
	logic [26:0] k100_prod_c, yq_prod_c;
	logic [50:0] offq_prod_c;
	logic [13:0] k_s1, y_s1;
	logic [7:0]  k100_s1, yq_s1;
	logic [22:0] k365_s1;
	logic [3:0]  mo_s1;
	logic [4:0]  d_s1, hr_s1;
	logic [5:0]  mi_s1, se_s1;
	logic [31:0] off_s1;
	logic [15:0] offq_s1;

	always_comb begin
		k_c = (start_year == 14'd0) ? 14'd0 : start_year - 14'd1;
		k100_prod_c = 27'(k_c) * 27'(dtas_pkg::DIV100_M);
		yq_prod_c = 27'(start_year) * 27'(dtas_pkg::DIV100_M);
		offq_prod_c = 51'(offset_seconds[31:7]) * 51'(dtas_pkg::DIV675_M);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1 <= k_c;
			y_s1 <= start_year;
			k100_s1 <= k100_prod_c[26:19];
			yq_s1 <= yq_prod_c[26:19];
			k365_s1 <= 23'(k_c) * 23'd365;
			mo_s1 <= start_month;
			d_s1 <= start_day;
			hr_s1 <= start_hour;
			mi_s1 <= start_minute;
			se_s1 <= start_second;
			off_s1 <= offset_seconds;
			offq_s1 <= offq_prod_c[50:35];
		end
	end

	// Stage 2: signed day count, seconds of day, offset remainder.
	logic [22:0] dby_c;
	logic        leap_in_c;
	logic        madj_c;
	logic signed [24:0] days_c;
	logic [31:0] offr_c;
	logic signed [24:0] days_s2;
	logic [16:0] sod_s2, offr_s2;
	logic [15:0] offq_s2;

	always_comb begin
		dby_c = k365_s1 + 23'(k_s1 >> 2) - 23'(k100_s1) + 23'(k100_s1 >> 2);
		leap_in_c = (y_s1[1:0] == 2'd0) &&
			((15'(y_s1) != 15'(yq_s1) * 15'd100) || (yq_s1[1:0] == 2'd0));
		madj_c = leap_in_c && (mo_s1 >= 4'd3) && (mo_s1 <= 4'd12);
		days_c = $signed({2'b00, dby_c}) + $signed(25'(dtas_pkg::month_start(mo_s1)))
			+ $signed(25'(madj_c)) + $signed(25'(d_s1)) - 25'sd1;
		offr_c = off_s1 - 32'(offq_s1) * 32'(dtas_pkg::SECS_PER_DAY);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			days_s2 <= days_c;
			sod_s2 <= 17'(hr_s1) * 17'd3600 + 17'(mi_s1) * 17'd60 + 17'(se_s1);
			offr_s2 <= offr_c[16:0];
			offq_s2 <= offq_s1;
		end
	end

	// Stage 3: carry whole days out of the seconds, clamp a negative total.
	logic [17:0] s_c, sr_c;
	logic [1:0]  c_c;
	logic signed [24:0] dsum_c;
	logic [22:0] dd_s3;
	logic [16:0] tod_s3;

	always_comb begin
		s_c = 18'(sod_s2) + 18'(offr_s2);
		if (s_c >= 18'd172800) begin
			c_c = 2'd2;
			sr_c = s_c - 18'd172800;
		end else if (s_c >= 18'(dtas_pkg::SECS_PER_DAY)) begin
			c_c = 2'd1;
			sr_c = s_c - 18'(dtas_pkg::SECS_PER_DAY);
		end else begin
			c_c = 2'd0;
			sr_c = s_c;
		end
		dsum_c = days_s2 + $signed(25'(offq_s2)) + $signed(25'(c_c));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (dsum_c < 0) begin
				dd_s3 <= 23'd0;
				tod_s3 <= 17'd0;
			end else begin
				dd_s3 <= dsum_c[22:0];
				tod_s3 <= sr_c[16:0];
			end
		end
	end

	// Stage 4: 400-year cycles, minutes of day.
	logic [46:0] n400_prod_c;
	logic [40:0] m60_prod_c;
	logic [22:0] dd_s4;
	logic [5:0]  n400_s4;
	logic [16:0] tod_s4;
	logic [10:0] m60_s4;

	always_comb begin
		n400_prod_c = 47'(dd_s3) * 47'(dtas_pkg::DIV400Y_M);
		m60_prod_c = 41'(tod_s3) * 41'(dtas_pkg::DIV60A_M);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dd_s4 <= dd_s3;
			n400_s4 <= n400_prod_c[46:41];
			tod_s4 <= tod_s3;
			m60_s4 <= m60_prod_c[33:23];
		end
	end

	// Stage 5: remainder in the 400-year cycle, hour and second.
	logic [22:0] hr_prod_c;
	logic [17:0] r1_s5;
	logic [5:0]  n400_s5;
	logic [10:0] m60_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  sec_s5;

	always_comb begin
		hr_prod_c = 23'(m60_s4) * 23'(dtas_pkg::DIV60B_M);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r1_s5 <= 18'(dd_s4 - 23'(n400_s4) * 23'd146097);
			n400_s5 <= n400_s4;
			m60_s5 <= m60_s4;
			hour_s5 <= hr_prod_c[21:17];
			sec_s5 <= 6'(tod_s4 - 17'(m60_s4) * 17'd60);
		end
	end

	// Stage 6: 100-year cycles, minute.
	logic [1:0]  n100_c;
	logic [17:0] r2_c;
	logic [15:0] r2_s6;
	logic [1:0]  n100_s6;
	logic [5:0]  n400_s6;
	logic [4:0]  hour_s6;
	logic [5:0]  min_s6, sec_s6;

	always_comb begin
		if (r1_s5 >= 18'd109572) begin
			n100_c = 2'd3;
			r2_c = r1_s5 - 18'd109572;
		end else if (r1_s5 >= 18'd73048) begin
			n100_c = 2'd2;
			r2_c = r1_s5 - 18'd73048;
		end else if (r1_s5 >= 18'd36524) begin
			n100_c = 2'd1;
			r2_c = r1_s5 - 18'd36524;
		end else begin
			n100_c = 2'd0;
			r2_c = r1_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s6 <= r2_c[15:0];
			n100_s6 <= n100_c;
			n400_s6 <= n400_s5;
			hour_s6 <= hour_s5;
			min_s6 <= 6'(m60_s5 - 11'(hour_s5) * 11'd60);
			sec_s6 <= sec_s5;
		end
	end

	// Stage 7: 4-year cycles.
	logic [31:0] n4_prod_c;
	logic [15:0] r2_s7;
	logic [4:0]  n4_s7;
	logic [1:0]  n100_s7;
	logic [5:0]  n400_s7;
	logic [4:0]  hour_s7;
	logic [5:0]  min_s7, sec_s7;

	always_comb begin
		n4_prod_c = 32'(r2_s6) * 32'(dtas_pkg::DIV4Y_M);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r2_s7 <= r2_s6;
			n4_s7 <= n4_prod_c[30:26];
			n100_s7 <= n100_s6;
			n400_s7 <= n400_s6;
			hour_s7 <= hour_s6;
			min_s7 <= min_s6;
			sec_s7 <= sec_s6;
		end
	end

	// Stage 8: single years, day of year.
	logic [10:0] r3_c;
	logic [1:0]  n1_c;
	logic [10:0] r4_c;
	logic [8:0]  r4_s8;
	logic [1:0]  n1_s8, n100_s8;
	logic [4:0]  n4_s8;
	logic [5:0]  n400_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  min_s8, sec_s8;

	always_comb begin
		r3_c = 11'(r2_s7 - 16'(n4_s7) * 16'd1461);
		if (r3_c >= 11'd1095) begin
			n1_c = 2'd3;
			r4_c = r3_c - 11'd1095;
		end else if (r3_c >= 11'd730) begin
			n1_c = 2'd2;
			r4_c = r3_c - 11'd730;
		end else if (r3_c >= 11'd365) begin
			n1_c = 2'd1;
			r4_c = r3_c - 11'd365;
		end else begin
			n1_c = 2'd0;
			r4_c = r3_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r4_s8 <= r4_c[8:0];
			n1_s8 <= n1_c;
			n4_s8 <= n4_s7;
			n100_s8 <= n100_s7;
			n400_s8 <= n400_s7;
			hour_s8 <= hour_s7;
			min_s8 <= min_s7;
			sec_s8 <= sec_s7;
		end
	end

	// Stage 9: year, leap flag, month search.
	logic        leap_c;
	logic [3:0]  mon_c;
	logic [8:0]  base_c, st_c;
	logic [16:0] year_s9;
	logic [3:0]  mon_s9;
	logic [4:0]  day_s9;
	logic [4:0]  hour_s9;
	logic [5:0]  min_s9, sec_s9;

	always_comb begin
		leap_c = (n1_s8 == 2'd3) && ((n4_s8 != 5'd24) || (n100_s8 == 2'd3));
		mon_c = 4'd1;
		base_c = 9'd0;
		st_c = 9'd0;
		for (int i = 2; i <= 12; i++) begin
			st_c = dtas_pkg::month_start(4'(i)) + 9'((leap_c && i >= 3) ? 1 : 0);
			if (r4_s8 >= st_c) begin
				mon_c = 4'(i);
				base_c = st_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s9 <= 17'(n400_s8) * 17'd400 + 17'(n100_s8) * 17'd100
				+ 17'(n4_s8) * 17'd4 + 17'(n1_s8) + 17'd1;
			mon_s9 <= mon_c;
			day_s9 <= 5'(r4_s8 - base_c + 9'd1);
			hour_s9 <= hour_s8;
			min_s9 <= min_s8;
			sec_s9 <= sec_s8;
		end
	end

	// Output register with the year clamp.
	logic ovf_c;

	always_comb begin
		ovf_c = year_s9 > 17'(MAX_YEAR);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ovf_c) begin
				end_year <= 14'(MAX_YEAR);
				end_month <= 4'd12;
				end_day <= 5'd31;
				end_hour <= 5'd23;
				end_minute <= 6'd59;
				end_second <= 6'd59;
			end else begin
				end_year <= year_s9[13:0];
				end_month <= mon_s9;
				end_day <= day_s9;
				end_hour <= hour_s9;
				end_minute <= min_s9;
				end_second <= sec_s9;
			end
			year_overflow <= ovf_c;
		end
	end

	// The input side is held only while a result waits at the output.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q)
		else $error("in_stall raised without a waiting result");

	// A clamped result always carries the last second of the year.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && year_overflow) |-> (end_month == 4'd12 && end_day == 5'd31
		&& end_hour == 5'd23 && end_minute == 6'd59 && end_second == 6'd59))
		else $error("clamped result is not the last second of the year");

	// Time of day and month stay in range for every delivered result.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_hour < 5'd24 && end_minute < 6'd60 && end_second < 6'd60
		&& end_month >= 4'd1 && end_month <= 4'd12 && end_day >= 5'd1))
		else $error("result field out of range");

	// A stage holds its valid bit while the output is stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(v_s9) && out_valid_q))
		else $error("pipeline advanced under stall");

endmodule

`default_nettype wire

### tb/datetime_add_seconds_checker.sv
// Checker for the date and time adder: watches both channels, predicts each result.
// Depends on nothing but the ports of datetime_add_seconds; instantiated by tb.
`timescale 1ns / 1ps

module datetime_add_seconds_checker #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [13:0] start_year,
	input  logic [3:0]  start_month,
	input  logic [4:0]  start_day,
	input  logic [4:0]  start_hour,
	input  logic [5:0]  start_minute,
	input  logic [5:0]  start_second,
	input  logic [31:0] offset_seconds,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [13:0] end_year,
	input  logic [3:0]  end_month,
	input  logic [4:0]  end_day,
	input  logic [4:0]  end_hour,
	input  logic [5:0]  end_minute,
	input  logic [5:0]  end_second,
	input  logic        year_overflow,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        ovf;
	} stamp_t;

	stamp_t expected_stamps[$];

	function automatic bit leap_year(longint unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic longint unsigned month_days(int m, bit leap);
		int unsigned tab[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
		return tab[m - 1] + ((leap && m >= 3) ? 1 : 0);
	endfunction

	function automatic stamp_t add_seconds(logic [13:0] y, logic [3:0] mo, logic [4:0] d,
			logic [4:0] hr, logic [5:0] mi, logic [5:0] se, logic [31:0] off);
		stamp_t s;
		longint k, days, total;
		longint unsigned t, dd, r, n400, n100, n4, n1, yr;
		int m;
		bit lp;
		days = 0;
		if (y != 0) begin
			k = y - 1;
			days = k * 365 + k / 4 - k / 100 + k / 400;
		end
		if (mo >= 1 && mo <= 12)
			days += month_days(mo, (mo >= 3) && leap_year(y));
		days += longint'(d) - 1;
		total = ((days * 24 + hr) * 60 + mi) * 60 + se + longint'(off);
		if (total < 0)
			total = 0;
		t = total;
		dd = t / 86400;
		r = t % 86400;
		s.hour = r / 3600;
		s.minute = (r / 60) % 60;
		s.second = r % 60;
		n400 = dd / 146097;
		r = dd % 146097;
		n100 = r / 36524;
		if (n100 > 3)
			n100 = 3;
		r -= n100 * 36524;
		n4 = r / 1461;
		r -= n4 * 1461;
		n1 = r / 365;
		if (n1 > 3)
			n1 = 3;
		r -= n1 * 365;
		yr = n400 * 400 + n100 * 100 + n4 * 4 + n1 + 1;
		lp = leap_year(yr);
		m = 12;
		while (m > 1 && r < month_days(m, lp))
			m--;
		s.month = m;
		s.day = r - month_days(m, lp) + 1;
		s.ovf = 1'b0;
		if (yr > MAX_YEAR) begin
			yr = MAX_YEAR;
			s.month = 12;
			s.day = 31;
			s.hour = 23;
			s.minute = 59;
			s.second = 59;
			s.ovf = 1'b1;
		end
		s.year = yr[13:0];
		return s;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		stamp_t e;
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_stamps.push_back(add_seconds(start_year, start_month, start_day,
					start_hour, start_minute, start_second, offset_seconds));
			if (out_valid && !out_stall) begin
				if (expected_stamps.size() == 0) begin
					report_mismatch("unexpected transaction", 1, 0);
				end else begin
					e = expected_stamps.pop_front();
					if (end_year != e.year) report_mismatch("end_year", end_year, e.year);
					if (end_month != e.month) report_mismatch("end_month", end_month, e.month);
					if (end_day != e.day) report_mismatch("end_day", end_day, e.day);
					if (end_hour != e.hour) report_mismatch("end_hour", end_hour, e.hour);
					if (end_minute != e.minute)
						report_mismatch("end_minute", end_minute, e.minute);
					if (end_second != e.second)
						report_mismatch("end_second", end_second, e.second);
					if (year_overflow != e.ovf)
						report_mismatch("year_overflow", year_overflow, e.ovf);
				end
			end
			pending <= expected_stamps.size();
		end
	end

endmodule

### tb/tb.sv
// Top of the date and time adder testbench: clock, reset, stimulus and verdict.
// Depends on datetime_add_seconds and datetime_add_seconds_checker.
`timescale 1ns / 1ps

module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [13:0] start_year = '0;
	logic [3:0]  start_month = '0;
	logic [4:0]  start_day = '0;
	logic [4:0]  start_hour = '0;
	logic [5:0]  start_minute = '0;
	logic [5:0]  start_second = '0;
	logic [31:0] offset_seconds = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [13:0] end_year;
	logic [3:0]  end_month;
	logic [4:0]  end_day;
	logic [4:0]  end_hour;
	logic [5:0]  end_minute;
	logic [5:0]  end_second;
	logic        year_overflow;
	int          errors;
	int          pending;
	bit          stim_done = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	datetime_add_seconds DUT (.*);

	datetime_add_seconds_checker checker_i (.*);

	function automatic int gap_length();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	task automatic send_stamp(logic [13:0] y, logic [3:0] mo, logic [4:0] d,
			logic [4:0] hr, logic [5:0] mi, logic [5:0] se, logic [31:0] off, bit burst);
		int gap;
		gap = burst ? 0 : gap_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		start_year <= y;
		start_month <= mo;
		start_day <= d;
		start_hour <= hr;
		start_minute <= mi;
		start_second <= se;
		offset_seconds <= off;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n)
			out_stall <= ($urandom_range(0, 9) < 3) && ((($time / 400) % 3) != 1);
	end

	initial begin
		bit burst;
		logic [31:0] off;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		send_stamp(1, 1, 1, 0, 0, 0, 0, 0);
		send_stamp(9999, 12, 31, 23, 59, 59, 0, 0);
		send_stamp(9999, 12, 31, 23, 59, 59, 1, 0);
		send_stamp(9999, 12, 31, 23, 59, 59, 32'hFFFFFFFF, 0);
		send_stamp(14'h3FFF, 4'hF, 5'h1F, 5'h1F, 6'h3F, 6'h3F, 32'hFFFFFFFF, 0);
		send_stamp(0, 0, 0, 0, 0, 0, 0, 0);
		send_stamp(1, 1, 0, 0, 0, 0, 100, 0);
		send_stamp(0, 5, 1, 0, 0, 0, 0, 0);
		send_stamp(0, 3, 1, 0, 0, 0, 0, 0);
		send_stamp(2000, 2, 28, 23, 59, 59, 1, 0);
		send_stamp(1900, 2, 28, 23, 59, 59, 1, 0);
		send_stamp(2024, 2, 29, 12, 0, 0, 86400, 0);
		send_stamp(2023, 13, 40, 30, 63, 63, 0, 0);
		send_stamp(2023, 0, 15, 0, 0, 0, 0, 0);
		send_stamp(1999, 12, 31, 23, 59, 59, 1, 0);
		send_stamp(2400, 12, 31, 0, 0, 0, 32'h80000000, 0);
		send_stamp(9998, 6, 1, 0, 0, 0, 32'hFFFFFFFF, 0);
		send_stamp(100, 3, 1, 0, 0, 0, 0, 0);
		for (int i = 0; i < 850; i++) begin
			burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 3))
				0: off = $urandom();
				1: off = $urandom_range(0, 100000);
				2: off = $urandom_range(0, 1) ? 32'hFFFFFFFF : 0;
				default: off = $urandom_range(0, 3) * 86400 - $urandom_range(0, 1);
			endcase
			if ($urandom_range(0, 9) == 0)
				send_stamp(14'($urandom()), 4'($urandom()), 5'($urandom()),
					5'($urandom()), 6'($urandom()), 6'($urandom()), $urandom(), burst);
			else
				send_stamp(14'($urandom_range(1, 9999)), 4'($urandom_range(1, 12)),
					5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
					6'($urandom_range(0, 59)), 6'($urandom_range(0, 59)), off, burst);
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		while (pending != 0 || out_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
